// ===== design/mbd_pkg.sv =====
// ----------------------------------------------------------------------------
// mbd_pkg: shared types and constants of the mipmap box downsampler
// Field widths, register indexes and level sizing.
// ----------------------------------------------------------------------------
package mbd_pkg;
	localparam int DEF_MAX_WIDTH    = 2048;
	localparam int DEF_MAX_CHANNELS = 4;
	localparam int DEF_MAX_LEVELS   = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd2;
	localparam int POS_W = 14;

	typedef struct packed {
		logic [3:0] level;
		logic [9:0] out_x;
		logic [9:0] out_y;
		logic [1:0] channel;
		logic [7:0] value;
		logic       last;
	} result_t;

	// travels down the chain of level cells
	typedef struct packed {
		logic       vld;
		logic [7:0] sample;
	} link_t;
endpackage

// ===== design/mbd_if.sv =====
// ----------------------------------------------------------------------------
// mbd_stream_if: valid/ready channel carrying a payload of type T
// ----------------------------------------------------------------------------
interface mbd_stream_if #(parameter type T = logic [7:0]) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== design/mipmap_box_downsampler_top.sv =====
// ----------------------------------------------------------------------------
// mipmap_box_downsampler_top: 2x2 box-filter mipmap chain generator
//
//  channel | dir | beat payload
//  in      | in  | sample (8b)
//  out     | out | level, out_x, out_y, channel, value, last
//  cfg     | in  | cfg_we, cfg_idx, cfg_data (no handshake)
//
// An input beat walks down the chain of level cells, each with a registered output
// stage; each cell reads its line memory through a register.
// For an item with n results: the beat is accepted, n+1 cells along the chain
// take a step (the cell past the last result fires nothing and only updates its
// own position and holds), then n result beats drain once the chain is idle.
// Input ready is low from the cycle after accept until the chain is idle and the queue is empty.
// Reset clears all positions and the pair holds; line memories need no clear.
// Output stalls simply hold the queue.
// ----------------------------------------------------------------------------
module mipmap_box_downsampler_top #(
	parameter int MAX_WIDTH    = mbd_pkg::DEF_MAX_WIDTH,
	parameter int MAX_CHANNELS = mbd_pkg::DEF_MAX_CHANNELS,
	parameter int MAX_LEVELS   = mbd_pkg::DEF_MAX_LEVELS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mbd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [mbd_pkg::CFG_DATA_W-1:0] cfg_data,
	mbd_stream_if.sink                     in,
	mbd_stream_if.source                   out
);
	import mbd_pkg::*;
	logic [11:0] w_q, h_q;
	logic [2:0]  c_q;
	logic [POS_W-1:0] w, h;
	logic [2:0]  nc;
	logic        busy, step, chain_busy;
	logic [MAX_LEVELS:0] cell_busy;
	link_t       link [MAX_LEVELS+2];
	result_t     res [MAX_LEVELS+1];
	result_t     qres [MAX_LEVELS];
	logic [MAX_LEVELS-1:0] qv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= 12'd2048;
			h_q <= 12'd2048;
			c_q <= 3'd4;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_WIDTH:    w_q <= cfg_data;
				REG_HEIGHT:   h_q <= cfg_data;
				REG_CHANNELS: c_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// saturate registers into legal range
	always_comb begin
		w = (w_q == '0) ? POS_W'(1) : ({2'b0, w_q} > POS_W'(MAX_WIDTH)) ? POS_W'(MAX_WIDTH) : {2'b0, w_q};
		h = (h_q == '0) ? POS_W'(1) : ({2'b0, h_q} > POS_W'(MAX_WIDTH)) ? POS_W'(MAX_WIDTH) : {2'b0, h_q};
		nc = (c_q == '0) ? 3'd1 : (c_q > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS) : c_q;
	end

	// chain idle and queue empty before the next beat
	assign chain_busy = |cell_busy;
	assign in.ready = !busy && !chain_busy;
	assign step = in.valid && in.ready;
	assign link[0].vld = step;
	assign link[0].sample = in.data;

	// level MAX_LEVELS only advances its position
	for (genvar k = 0; k <= MAX_LEVELS; k++) begin : g_cell
		mbd_level_cell #(
			.MAX_WIDTH(MAX_WIDTH), .MAX_CHANNELS(MAX_CHANNELS),
			.LEVEL(k), .LAST_CELL(k == MAX_LEVELS)
		) u_cell (
			.clk, .arst_n, .din(link[k]),
			.wk(w >> k), .hk(h >> k), .nc,
			.busy(cell_busy[k]), .dout(link[k+1]), .res(res[k])
		);
	end

	for (genvar k = 0; k < MAX_LEVELS; k++) begin : g_q
		assign qv[k] = link[k+1].vld;
		assign qres[k] = res[k];
	end

	mbd_out_queue #(.N(MAX_LEVELS)) u_q (
		.clk, .arst_n, .hold(chain_busy), .load_vld(qv), .load_res(qres), .busy, .out
	);
endmodule

// ===== design/mbd_level_cell.sv =====
// ----------------------------------------------------------------------------
// mbd_level_cell: one mipmap level
// Tracks position of incoming level-k samples, pairs columns and rows, and
// forwards the finished level-(k+1) sample to the next cell from a registered output stage.
// ----------------------------------------------------------------------------
module mbd_level_cell #(
	parameter int MAX_WIDTH    = 2048,
	parameter int MAX_CHANNELS = 4,
	parameter int LEVEL        = 0,
	parameter int LAST_CELL    = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mbd_pkg::link_t       din,
	input  logic [mbd_pkg::POS_W-1:0] wk,
	input  logic [mbd_pkg::POS_W-1:0] hk,
	input  logic [2:0]           nc,
	output logic                 busy,      // a beat sits in the output stage
	output mbd_pkg::link_t       dout,
	output mbd_pkg::result_t     res
);
	import mbd_pkg::*;
	localparam int LW    = (MAX_WIDTH >> (LEVEL + 1)) > 0 ? (MAX_WIDTH >> (LEVEL + 1)) : 1;
	localparam int DEPTH = LW * MAX_CHANNELS;
	localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int CW    = MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1;

	logic [POS_W-1:0] x_q, y_q;
	logic [1:0]       ch_q;
	logic [7:0]       hold_q [MAX_CHANNELS];
	logic [8:0]       line_mem [DEPTH];

	// output stage: registered line read plus the pair it completes
	logic             vld_s1, fire_s1;
	logic [POS_W-1:0] x_s1, y_s1;
	logic [1:0]       ch_s1;
	logic [8:0]       pair_s1, rd_s1;

	logic [POS_W-1:0] x, y, nx, ny;
	logic [1:0]       ch, nch;
	logic [2:0]       ch1;
	logic             active, inblk, is_odd_x, is_odd_y;
	logic [8:0]       pair;
	logic [9:0]       total;
	logic [AW-1:0]    idx;

	assign active = din.vld && (wk != '0) && (hk != '0);

	always_comb begin
		x = (x_q >= wk) ? '0 : x_q;
		y = (y_q >= hk) ? '0 : y_q;
		ch = ({1'b0, ch_q} >= nc) ? 2'd0 : ch_q;
		ch1 = {1'b0, ch} + 3'd1;
		nx = x; ny = y; nch = ch1[1:0];
		if (ch1 >= nc) begin
			nch = 2'd0;
			nx = x + 1'b1;
			if (nx >= wk) begin
				nx = '0;
				ny = y + 1'b1;
				if (ny >= hk) ny = '0;
			end
		end
		inblk = (x < {wk[POS_W-1:1], 1'b0}) && (y < {hk[POS_W-1:1], 1'b0});
		is_odd_x = x[0];
		is_odd_y = y[0];
		pair = {1'b0, hold_q[ch[CW-1:0]]} + {1'b0, din.sample};
		idx = AW'(({x[POS_W-1:1]} * MAX_CHANNELS) + ch);
	end

	always_ff @(posedge clk) begin
		if (active && inblk && !LAST_CELL[0] && is_odd_x && !is_odd_y)
			line_mem[idx] <= pair;
		if (active) begin
			rd_s1 <= line_mem[idx];
			pair_s1 <= pair;
			x_s1 <= x;
			y_s1 <= y;
			ch_s1 <= ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
			ch_q <= '0;
			for (int i = 0; i < MAX_CHANNELS; i++) hold_q[i] <= '0;
			vld_s1 <= 1'b0;
			fire_s1 <= 1'b0;
		end else begin
			vld_s1 <= active;
			fire_s1 <= active && inblk && !LAST_CELL[0] && is_odd_x && is_odd_y;
			if (active) begin
				x_q <= nx;
				y_q <= ny;
				ch_q <= nch;
				if (inblk && !LAST_CELL[0] && !is_odd_x)
					hold_q[ch[CW-1:0]] <= din.sample;
			end
		end
	end

	assign busy = vld_s1;

	always_comb begin
		total = {1'b0, rd_s1} + {1'b0, pair_s1};
		dout.vld = fire_s1;
		dout.sample = total[9:2];
		res.level = 4'(LEVEL + 1);
		res.out_x = x_s1[10:1];
		res.out_y = y_s1[10:1];
		res.channel = ch_s1;
		res.value = total[9:2];
		res.last = 1'b0;
	end
endmodule

// ===== design/mbd_out_queue.sv =====
// ----------------------------------------------------------------------------
// mbd_out_queue: result queue
// Collects the results of one beat and drains them one per cycle while the chain is idle and out.ready is high.
// ----------------------------------------------------------------------------
module mbd_out_queue #(
	parameter int N = 11
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 hold,      // results still moving down the chain
	input  logic [N-1:0]         load_vld,
	input  mbd_pkg::result_t     load_res [N],
	output logic                 busy,
	mbd_stream_if.source         out
);
	import mbd_pkg::*;
	logic [N-1:0] pend_q;
	result_t      res_q [N];
	logic [N-1:0] first_oh, rest;
	logic [$clog2(N+1)-1:0] sel;

	always_comb begin
		first_oh = pend_q & (~pend_q + 1'b1);
		rest = pend_q & ~first_oh;
		sel = '0;
		for (int i = N - 1; i >= 0; i--)
			if (pend_q[i]) sel = ($clog2(N+1))'(i);
	end

	assign busy = |pend_q;
	assign out.valid = (|pend_q) && !hold;
	always_comb begin
		out.data = res_q[sel[$clog2(N)>0?$clog2(N)-1:0:0]];
		out.data.last = (rest == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= '0;
		else if (|load_vld) pend_q <= pend_q | load_vld;
		else if (out.valid && out.ready) pend_q <= rest;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < N; i++)
			if (load_vld[i]) res_q[i] <= load_res[i];
	end
endmodule

// ===== design/mbd_checker.sv =====
// ----------------------------------------------------------------------------
// mbd_checker: port-level checks of the mipmap downsampler
// ----------------------------------------------------------------------------
module mbd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [3:0] out_level,
	input logic out_last
);
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken during drain");
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_level != 4'd0)) else $error("level zero");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_next_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid &&
		out_level == $past(out_level) + 4'd1) else $error("level order");
endmodule

bind mipmap_box_downsampler_top mbd_checker u_chk (
	.clk, .arst_n, .in_valid(in.valid), .in_ready(in.ready),
	.out_valid(out.valid), .out_ready(out.ready),
	.out_level(out.data.level), .out_last(out.data.last)
);
